// ----- rtl/bfsa_pkg.sv -----
// Shared types and constants for the best-fit segment allocator.
// No dependencies; every other file of the block imports this package.
package bfsa_pkg;

	localparam int FIELD_BITS  = 16;
	localparam int MODE_BITS   = 2;
	localparam int STATUS_BITS = 3;

	// Request modes.
	localparam logic [MODE_BITS-1:0] MODE_INIT  = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_ALLOC = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_FREE  = 2'd2;
	localparam logic [MODE_BITS-1:0] MODE_CLAIM = 2'd3;

	// Result status codes.
	localparam logic [STATUS_BITS-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_BITS-1:0] ST_NOFIT    = 3'd1;
	localparam logic [STATUS_BITS-1:0] ST_NOTUSED  = 3'd2;
	localparam logic [STATUS_BITS-1:0] ST_BADRANGE = 3'd3;
	localparam logic [STATUS_BITS-1:0] ST_FULL     = 3'd4;

	// Configuration register indexes (address bit 2).
	localparam logic CFG_REGION_START = 1'b0;
	localparam logic CFG_REGION_SIZE  = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ROUND,
		S_SCAN,
		S_PLAN,
		S_SHIFT_DN,
		S_SHIFT_UP,
		S_COMMIT,
		S_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_ROUND,
		OP_SCAN,
		OP_PLAN,
		OP_SHIFT_DN,
		OP_SHIFT_UP,
		OP_COMMIT,
		OP_EMIT
	} op_t;

	typedef struct packed {
		op_t op;
	} ctl_cmd_t;

	typedef struct packed {
		logic is_init;
		logic round_done;
		logic scan_done;
		logic plan_err;
		logic plan_rm;
		logic plan_ins;
		logic shift_done;
	} dp_stat_t;

endpackage

// ----- rtl/bfsa_if.sv -----
// Request and result channel interfaces of the segment allocator.
// Depends on bfsa_pkg for the field widths.
interface bfsa_req_if import bfsa_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [MODE_BITS-1:0]  mode;
	logic [FIELD_BITS-1:0] block_address;
	logic [FIELD_BITS-1:0] block_size;

	modport source(output valid, mode, block_address, block_size, input ready);
	modport sink(input valid, mode, block_address, block_size, output ready);
endinterface

interface bfsa_rsp_if import bfsa_pkg::*;;
	logic                   valid;
	logic                   ready;
	logic [STATUS_BITS-1:0] status;
	logic [FIELD_BITS-1:0]  granted_address;
	logic [FIELD_BITS-1:0]  granted_size;

	modport source(output valid, status, granted_address, granted_size, input ready);
	modport sink(input valid, status, granted_address, granted_size, output ready);
endinterface

// ----- rtl/bfsa_ctrl.sv -----
// Sequencing state machine of the segment allocator.
// Depends on bfsa_pkg; drives the datapath through ctl_cmd_t.
module bfsa_ctrl import bfsa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output ctl_cmd_t cmd,
	input  dp_stat_t stat
);

	state_t state_q, state_nxt;
	logic   valid_q;
	logic   emit;

	// State register and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (emit) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Next state and command decode.
	always_comb begin
		state_nxt = state_q;
		cmd.op    = OP_NONE;
		in_ready  = 1'b0;
		emit      = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op    = OP_LOAD;
					state_nxt = S_ROUND;
				end
			end
			S_ROUND: begin
				if (stat.is_init) begin
					state_nxt = S_COMMIT;
				end else begin
					cmd.op = OP_ROUND;
					if (stat.round_done) begin
						state_nxt = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				cmd.op = OP_SCAN;
				if (stat.scan_done) begin
					state_nxt = S_PLAN;
				end
			end
			S_PLAN: begin
				cmd.op = OP_PLAN;
				priority if (stat.plan_err) begin
					state_nxt = S_DONE;
				end else if (stat.plan_rm) begin
					state_nxt = S_SHIFT_DN;
				end else if (stat.plan_ins) begin
					state_nxt = S_SHIFT_UP;
				end else begin
					state_nxt = S_COMMIT;
				end
			end
			S_SHIFT_DN: begin
				cmd.op = OP_SHIFT_DN;
				if (stat.shift_done) begin
					state_nxt = S_COMMIT;
				end
			end
			S_SHIFT_UP: begin
				cmd.op = OP_SHIFT_UP;
				if (stat.shift_done) begin
					state_nxt = S_COMMIT;
				end
			end
			S_COMMIT: begin
				cmd.op    = OP_COMMIT;
				state_nxt = S_DONE;
			end
			S_DONE: begin
				if (!valid_q || out_ready) begin
					cmd.op    = OP_EMIT;
					emit      = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	assign out_valid = valid_q;

endmodule

// ----- rtl/bfsa_dp.sv -----
// Datapath of the segment allocator: segment tables, scan trackers, plan and result.
// Depends on bfsa_pkg; commanded by bfsa_ctrl.
module bfsa_dp import bfsa_pkg::*; #(
	parameter int FREE_ENTRIES = 16,
	parameter int USED_ENTRIES = 16,
	parameter int PAGE_BYTES   = 4,
	parameter int ADDR_BITS    = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ctl_cmd_t               cmd,
	output dp_stat_t               stat,
	input  logic [MODE_BITS-1:0]   mode,
	input  logic [FIELD_BITS-1:0]  block_address,
	input  logic [FIELD_BITS-1:0]  block_size,
	input  logic [FIELD_BITS-1:0]  region_start,
	input  logic [FIELD_BITS-1:0]  region_size,
	output logic [STATUS_BITS-1:0] status,
	output logic [FIELD_BITS-1:0]  granted_address,
	output logic [FIELD_BITS-1:0]  granted_size
);

	localparam int AW  = ADDR_BITS;
	localparam int SLW = AW + 1;
	localparam int LW  = ((AW > FIELD_BITS) ? AW : FIELD_BITS) + 2;
	localparam int FI  = $clog2(FREE_ENTRIES);
	localparam int CW  = $clog2(FREE_ENTRIES + 1);
	localparam int UI  = (USED_ENTRIES > 1) ? $clog2(USED_ENTRIES) : 1;
	localparam int MAXN = (FREE_ENTRIES > USED_ENTRIES) ? FREE_ENTRIES : USED_ENTRIES;
	localparam int SCAN_LEN = (MAXN > FIELD_BITS) ? MAXN : FIELD_BITS;
	localparam int SW  = $clog2(SCAN_LEN + 1);
	localparam int RW  = $clog2(PAGE_BYTES) + 1;
	localparam int RECIP = (1 << FIELD_BITS) / PAGE_BYTES;

	function automatic logic [LW-1:0] amask(input logic [LW-1:0] v);
		amask = LW'(v[AW-1:0]);
	endfunction

	// Request registers and page rounding.
	logic [MODE_BITS-1:0]    mode_q;
	logic [AW-1:0]           addr_q;
	logic [FIELD_BITS-1:0]   size_q;
	logic [1:0]              rb_q;
	logic [2*FIELD_BITS-1:0] prod_q;
	logic [FIELD_BITS-1:0]   qp_q;
	logic [RW-1:0]           rem_q;
	logic [RW-1:0]           rem_t, rem_n;
	logic [LW-1:0]           want;

	// Segment tables.
	logic [AW-1:0]   fstart_q [FREE_ENTRIES];
	logic [SLW-1:0]  flen_q [FREE_ENTRIES];
	logic [CW-1:0]   cnt_q;
	logic [AW-1:0]   ustart_q [USED_ENTRIES];
	logic [SLW-1:0]  ulen_q [USED_ENTRIES];
	logic [USED_ENTRIES-1:0] uvalid_q;

	// Scan trackers.
	logic [SW-1:0]  s_q;
	logic           best_f_q, cand_f_q, pre_open_q, next_f_q, slot_f_q, match_f_q;
	logic [FI-1:0]  best_idx_q, cand_idx_q;
	logic [AW-1:0]  best_start_q, cand_start_q, prev_start_q, next_start_q;
	logic [SLW-1:0] best_len_q, cand_len_q, prev_len_q, next_len_q, match_len_q;
	logic [CW-1:0]  pos_q;
	logic [UI-1:0]  slot_q, match_idx_q;

	// Plan registers.
	logic           rm_q, ins_q, upd_q, uset_q, uclr_q;
	logic [FI-1:0]  ins_idx_q, upd_idx_q;
	logic [AW-1:0]  ins_start_q, upd_start_q, unew_start_q;
	logic [SLW-1:0] ins_len_q, upd_len_q, unew_len_q;
	logic [UI-1:0]  uidx_q;
	logic [CW-1:0]  j_q;

	// Result and output registers.
	logic [STATUS_BITS-1:0] res_status_q, out_status_q;
	logic [FIELD_BITS-1:0]  res_addr_q, res_size_q, out_addr_q, out_size_q;

	// Table read port.
	logic [FI-1:0]  rd_idx;
	logic [AW-1:0]  rd_start;
	logic [SLW-1:0] rd_len;
	logic [UI-1:0]  us_idx;
	logic           fv, uv;

	// Plan logic.
	logic                   pl_err, pl_rm, pl_ins, pl_upd, pl_uset, pl_uclr;
	logic [STATUS_BITS-1:0] pl_st;
	logic [FI-1:0]          pl_rm_idx, pl_ins_idx, pl_upd_idx;
	logic [AW-1:0]          pl_ins_start, pl_upd_start, pl_ustart;
	logic [SLW-1:0]         pl_ins_len, pl_upd_len, pl_ulen;
	logic [UI-1:0]          pl_uidx;
	logic [LW-1:0]          pl_gaddr, pl_gsize;
	logic                   mprev, mnext;
	logic [LW-1:0]          c_bs, c_be, c_en;

	// Init values.
	logic [AW-1:0] ini_st;
	logic [LW-1:0] ini_room, ini_len;

	logic dn_go, up_go;

	// Size modulo the page: the reciprocal estimate of the quotient is exact or one low,
	// so one compare and subtract finishes the remainder.
	always_comb begin
		rem_t = RW'(size_q - qp_q);
		rem_n = (rem_t >= RW'(PAGE_BYTES)) ? rem_t - RW'(PAGE_BYTES) : rem_t;
		want  = LW'(size_q) + ((rem_q == '0) ? '0 : LW'(PAGE_BYTES) - LW'(rem_q));
	end

	// Read address mux and valid windows.
	always_comb begin
		unique case (cmd.op)
			OP_SHIFT_DN: rd_idx = FI'(j_q + CW'(1));
			OP_SHIFT_UP: rd_idx = FI'(j_q - CW'(1));
			default:     rd_idx = FI'(s_q);
		endcase
		rd_start = fstart_q[rd_idx];
		rd_len   = flen_q[rd_idx];
		us_idx   = UI'(s_q);
		fv       = s_q < SW'(cnt_q);
		uv       = s_q < SW'(USED_ENTRIES);
		dn_go    = ({1'b0, j_q} + (CW+1)'(1)) < {1'b0, cnt_q};
		up_go    = j_q != CW'(ins_idx_q);
	end

	// Init segment, clipped to the end of the address space.
	always_comb begin
		ini_st   = AW'(region_start);
		ini_room = (LW'(1) << AW) - LW'(ini_st);
		ini_len  = (LW'(region_size) > ini_room) ? ini_room : LW'(region_size);
	end

	// Decide the table edits from the scan results.
	always_comb begin
		pl_err       = 1'b0;
		pl_st        = ST_OK;
		pl_rm        = 1'b0;
		pl_ins       = 1'b0;
		pl_upd       = 1'b0;
		pl_uset      = 1'b0;
		pl_uclr      = 1'b0;
		pl_rm_idx    = best_idx_q;
		pl_ins_idx   = FI'(pos_q);
		pl_upd_idx   = best_idx_q;
		pl_ins_start = addr_q;
		pl_ins_len   = match_len_q;
		pl_upd_start = best_start_q;
		pl_upd_len   = best_len_q;
		pl_ustart    = addr_q;
		pl_ulen      = SLW'(want);
		pl_uidx      = slot_q;
		pl_gaddr     = LW'(addr_q);
		pl_gsize     = want;
		c_bs         = LW'(cand_start_q);
		c_be         = LW'(cand_start_q) + LW'(cand_len_q);
		c_en         = LW'(addr_q) + LW'(size_q);
		mprev        = (pos_q != '0) &&
			(LW'(prev_start_q) + LW'(prev_len_q) == LW'(addr_q));
		mnext        = next_f_q && (LW'(addr_q) + LW'(match_len_q) == LW'(next_start_q));
		unique case (mode_q)
			MODE_ALLOC: begin
				if (want == '0 || !best_f_q) begin
					pl_err = 1'b1;
					pl_st  = ST_NOFIT;
				end else if (!slot_f_q) begin
					pl_err = 1'b1;
					pl_st  = ST_FULL;
				end else begin
					pl_uset   = 1'b1;
					pl_ustart = best_start_q;
					pl_gaddr  = LW'(best_start_q);
					if (LW'(best_len_q) == want) begin
						pl_rm = 1'b1;
					end else begin
						pl_upd       = 1'b1;
						pl_upd_start = AW'(LW'(best_start_q) + want);
						pl_upd_len   = SLW'(LW'(best_len_q) - want);
					end
				end
			end
			MODE_FREE: begin
				pl_gsize = LW'(match_len_q);
				pl_uidx  = match_idx_q;
				if (!match_f_q) begin
					pl_err = 1'b1;
					pl_st  = ST_NOTUSED;
				end else begin
					pl_uclr = 1'b1;
					priority if (mprev && mnext) begin
						pl_upd       = 1'b1;
						pl_upd_idx   = FI'(pos_q - CW'(1));
						pl_upd_start = prev_start_q;
						pl_upd_len   = SLW'(amask(LW'(prev_len_q) + LW'(match_len_q) +
							LW'(next_len_q)));
						pl_rm        = 1'b1;
						pl_rm_idx    = FI'(pos_q);
					end else if (mprev) begin
						pl_upd       = 1'b1;
						pl_upd_idx   = FI'(pos_q - CW'(1));
						pl_upd_start = prev_start_q;
						pl_upd_len   = SLW'(amask(LW'(prev_len_q) + LW'(match_len_q)));
					end else if (mnext) begin
						pl_upd       = 1'b1;
						pl_upd_idx   = FI'(pos_q);
						pl_upd_start = addr_q;
						pl_upd_len   = SLW'(amask(LW'(next_len_q) + LW'(match_len_q)));
					end else if (cnt_q == CW'(FREE_ENTRIES)) begin
						pl_err  = 1'b1;
						pl_st   = ST_FULL;
						pl_uclr = 1'b0;
					end else begin
						pl_ins = 1'b1;
					end
				end
			end
			MODE_CLAIM: begin
				pl_gsize     = LW'(size_q);
				pl_ulen      = SLW'(size_q);
				pl_rm_idx    = cand_idx_q;
				pl_upd_idx   = cand_idx_q;
				pl_upd_start = cand_start_q;
				pl_upd_len   = SLW'(LW'(addr_q) - c_bs);
				pl_ins_idx   = cand_idx_q + FI'(1);
				pl_ins_start = AW'(c_en);
				pl_ins_len   = SLW'(c_be - c_en);
				if (size_q == '0 || !cand_f_q || LW'(addr_q) > c_be || c_en > c_be) begin
					pl_err = 1'b1;
					pl_st  = ST_BADRANGE;
				end else if (!slot_f_q) begin
					pl_err = 1'b1;
					pl_st  = ST_FULL;
				end else begin
					pl_uset = 1'b1;
					priority if (LW'(addr_q) == c_bs && LW'(size_q) == LW'(cand_len_q)) begin
						pl_rm = 1'b1;
					end else if (LW'(addr_q) == c_bs) begin
						pl_upd       = 1'b1;
						pl_upd_start = AW'(c_en);
						pl_upd_len   = SLW'(LW'(cand_len_q) - LW'(size_q));
					end else if (c_en < c_be) begin
						if (cnt_q == CW'(FREE_ENTRIES)) begin
							pl_err  = 1'b1;
							pl_st   = ST_FULL;
							pl_uset = 1'b0;
						end else begin
							pl_ins = 1'b1;
							pl_upd = 1'b1;
						end
					end else begin
						pl_upd = 1'b1;
					end
				end
			end
			default: begin
				pl_err = 1'b0;
			end
		endcase
	end

	// Status toward the controller.
	always_comb begin
		stat.is_init    = mode_q == MODE_INIT;
		stat.round_done = rb_q == 2'd2;
		stat.scan_done  = s_q == SW'(SCAN_LEN - 1);
		stat.plan_err   = pl_err;
		stat.plan_rm    = pl_rm;
		stat.plan_ins   = pl_ins;
		stat.shift_done = (cmd.op == OP_SHIFT_UP) ? !up_go : !dn_go;
	end

	// Control state: free count and used valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			uvalid_q <= '0;
		end else if (cmd.op == OP_COMMIT) begin
			if (mode_q == MODE_INIT) begin
				cnt_q    <= (ini_len != '0) ? CW'(1) : '0;
				uvalid_q <= '0;
			end else begin
				if (rm_q) begin
					cnt_q <= cnt_q - CW'(1);
				end else if (ins_q) begin
					cnt_q <= cnt_q + CW'(1);
				end
				if (uset_q) begin
					uvalid_q[uidx_q] <= 1'b1;
				end else if (uclr_q) begin
					uvalid_q[uidx_q] <= 1'b0;
				end
			end
		end
	end

	// Free table writes: shifts, edits and init.
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_SHIFT_DN: begin
				if (dn_go) begin
					fstart_q[FI'(j_q)] <= rd_start;
					flen_q[FI'(j_q)]   <= rd_len;
				end
			end
			OP_SHIFT_UP: begin
				if (up_go) begin
					fstart_q[FI'(j_q)] <= rd_start;
					flen_q[FI'(j_q)]   <= rd_len;
				end
			end
			OP_COMMIT: begin
				if (mode_q == MODE_INIT) begin
					fstart_q[0] <= ini_st;
					flen_q[0]   <= SLW'(ini_len);
				end else begin
					if (upd_q) begin
						fstart_q[upd_idx_q] <= upd_start_q;
						flen_q[upd_idx_q]   <= upd_len_q;
					end
					if (ins_q) begin
						fstart_q[ins_idx_q] <= ins_start_q;
						flen_q[ins_idx_q]   <= ins_len_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Used table payload.
	always_ff @(posedge clk) begin
		if (cmd.op == OP_COMMIT && mode_q != MODE_INIT && uset_q) begin
			ustart_q[uidx_q] <= unew_start_q;
			ulen_q[uidx_q]   <= unew_len_q;
		end
	end

	// Request capture, rounding, scan, plan and result registers.
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				mode_q     <= mode;
				addr_q     <= AW'(block_address);
				size_q     <= block_size;
				rb_q       <= '0;
				rem_q      <= '0;
				s_q        <= '0;
				best_f_q   <= 1'b0;
				cand_f_q   <= 1'b0;
				next_f_q   <= 1'b0;
				slot_f_q   <= 1'b0;
				match_f_q  <= 1'b0;
				pre_open_q <= 1'b1;
				pos_q      <= '0;
			end
			OP_ROUND: begin
				// Three steps: reciprocal product, quotient times page, remainder.
				rb_q <= rb_q + 2'd1;
				if (rb_q == 2'd0) begin
					prod_q <= (2*FIELD_BITS)'(size_q) * (2*FIELD_BITS)'(RECIP);
				end
				if (rb_q == 2'd1) begin
					qp_q <= prod_q[FIELD_BITS +: FIELD_BITS] * FIELD_BITS'(PAGE_BYTES);
				end
				if (rb_q == 2'd2) begin
					rem_q <= rem_n;
				end
			end
			OP_SCAN: begin
				s_q <= s_q + SW'(1);
				if (fv) begin
					if (LW'(rd_len) >= want && (!best_f_q || rd_len < best_len_q)) begin
						best_f_q     <= 1'b1;
						best_idx_q   <= rd_idx;
						best_start_q <= rd_start;
						best_len_q   <= rd_len;
					end
					if (rd_start <= addr_q) begin
						cand_f_q     <= 1'b1;
						cand_idx_q   <= rd_idx;
						cand_start_q <= rd_start;
						cand_len_q   <= rd_len;
					end
					if (pre_open_q) begin
						if (rd_start <= addr_q) begin
							pos_q        <= pos_q + CW'(1);
							prev_start_q <= rd_start;
							prev_len_q   <= rd_len;
						end else begin
							pre_open_q   <= 1'b0;
							next_f_q     <= 1'b1;
							next_start_q <= rd_start;
							next_len_q   <= rd_len;
						end
					end
				end
				if (uv) begin
					if (!uvalid_q[us_idx] && !slot_f_q) begin
						slot_f_q <= 1'b1;
						slot_q   <= us_idx;
					end
					if (uvalid_q[us_idx] && !match_f_q && ustart_q[us_idx] == addr_q) begin
						match_f_q   <= 1'b1;
						match_idx_q <= us_idx;
						match_len_q <= ulen_q[us_idx];
					end
				end
			end
			OP_PLAN: begin
				rm_q         <= pl_rm;
				ins_q        <= pl_ins;
				upd_q        <= pl_upd;
				uset_q       <= pl_uset;
				uclr_q       <= pl_uclr;
				ins_idx_q    <= pl_ins_idx;
				upd_idx_q    <= pl_upd_idx;
				ins_start_q  <= pl_ins_start;
				ins_len_q    <= pl_ins_len;
				upd_start_q  <= pl_upd_start;
				upd_len_q    <= pl_upd_len;
				unew_start_q <= pl_ustart;
				unew_len_q   <= pl_ulen;
				uidx_q       <= pl_uidx;
				j_q          <= pl_rm ? CW'(pl_rm_idx) : cnt_q;
				res_status_q <= pl_st;
				res_addr_q   <= pl_err ? '0 : FIELD_BITS'(pl_gaddr);
				res_size_q   <= pl_err ? '0 : FIELD_BITS'(pl_gsize);
			end
			OP_SHIFT_DN: begin
				if (dn_go) begin
					j_q <= j_q + CW'(1);
				end
			end
			OP_SHIFT_UP: begin
				if (up_go) begin
					j_q <= j_q - CW'(1);
				end
			end
			OP_COMMIT: begin
				if (mode_q == MODE_INIT) begin
					res_status_q <= ST_OK;
					res_addr_q   <= FIELD_BITS'(ini_st);
					res_size_q   <= FIELD_BITS'(ini_len);
				end
			end
			OP_EMIT: begin
				out_status_q <= res_status_q;
				out_addr_q   <= res_addr_q;
				out_size_q   <= res_size_q;
			end
			default: begin
			end
		endcase
	end

	assign status          = out_status_q;
	assign granted_address = out_addr_q;
	assign granted_size    = out_size_q;

endmodule

// ----- rtl/best_fit_segment_allocator_unit.sv -----
// Best-fit segment allocator, top level with the configuration registers.
// Init goes straight to commit; other requests round the size to whole pages, scan the
// tables one entry per cycle, plan, shift the free table if needed, and commit.
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset (arst_n low) empties both tables and clears both configuration registers.
module best_fit_segment_allocator_unit import bfsa_pkg::*; #(
	parameter int FREE_ENTRIES = 16,
	parameter int USED_ENTRIES = 16,
	parameter int PAGE_BYTES   = 4,
	parameter int ADDR_BITS    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	bfsa_req_if.sink    req,
	bfsa_rsp_if.source  rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [FIELD_BITS-1:0] region_start_q, region_size_q;
	ctl_cmd_t cmd;
	dp_stat_t stat;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_start_q <= '0;
			region_size_q  <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == CFG_REGION_SIZE) begin
				region_size_q <= pwdata[FIELD_BITS-1:0];
			end else begin
				region_start_q <= pwdata[FIELD_BITS-1:0];
			end
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == CFG_REGION_START) ? {16'd0, region_start_q} :
		{16'd0, region_size_q};

	bfsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	bfsa_dp #(
		.FREE_ENTRIES (FREE_ENTRIES),
		.USED_ENTRIES (USED_ENTRIES),
		.PAGE_BYTES   (PAGE_BYTES),
		.ADDR_BITS    (ADDR_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.mode            (req.mode),
		.block_address   (req.block_address),
		.block_size      (req.block_size),
		.region_start    (region_start_q),
		.region_size     (region_size_q),
		.status          (rsp.status),
		.granted_address (rsp.granted_address),
		.granted_size    (rsp.granted_size)
	);

endmodule
